// File: rtl/heightmap_triangle_height_query_defines.svh
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HTQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("htq assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define HTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("htq assertion failed");

`endif

// File: rtl/htq_pkg.sv
package htq_pkg;

	localparam int VERTS_PER_ROW = 64;
	localparam int VERTS_PER_COL = 64;
	localparam int COL_W  = $clog2(VERTS_PER_ROW);
	localparam int ROW_W  = $clog2(VERTS_PER_COL);
	localparam int ADDR_W = $clog2(VERTS_PER_ROW * VERTS_PER_COL);
	localparam int DEPTH  = VERTS_PER_ROW * VERTS_PER_COL;

	localparam int SAMPLE_W = 16;
	localparam int XS_OFF   = (VERTS_PER_ROW - 1) * 128;
	localparam int ZS_OFF   = (VERTS_PER_COL - 1) * 128;
	// dividend bias: cs << BIAS_SH keeps every dividend non-negative
	localparam int BIAS_SH  = 23;
	localparam int DIV_BITS = 32;
	localparam int CNT_W    = $clog2(DIV_BITS);
	localparam int Q_W      = 26;
	localparam int ACC_W    = 46;

	localparam logic [7:0]  CS_RESET = 8'd10;
	localparam logic [15:0] HS_RESET = 16'd128;

	localparam logic REG_CELL_SPACING = 1'b0;
	localparam logic REG_HEIGHT_SCALE = 1'b1;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic [1:0] CORNER_TL = 2'd0;
	localparam logic [1:0] CORNER_TR = 2'd1;
	localparam logic [1:0] CORNER_BL = 2'd2;
	localparam logic [1:0] CORNER_BR = 2'd3;

	typedef struct packed {
		logic       wr_load;
		logic       wr_en;
		logic       div_load;
		logic       div_step;
		logic       post;
		logic       rd_en;
		logic [1:0] rd_corner;
		logic       cap_en;
		logic [1:0] cap_corner;
		logic       sel;
		logic       mul1;
		logic       mul2;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

	function automatic logic [ADDR_W-1:0] grid_addr(input logic [7:0] r, input logic [7:0] c);
		return ADDR_W'(int'(r) * VERTS_PER_ROW + int'(c));
	endfunction

endpackage

// File: rtl/htq_ifs.sv
interface htq_req_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [5:0]         grid_row;
	logic [5:0]         grid_col;
	logic [7:0]         raw_height;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_z;

	modport source (output valid, func, grid_row, grid_col, raw_height, pos_x, pos_z,
		input ready);
	modport sink (input valid, func, grid_row, grid_col, raw_height, pos_x, pos_z,
		output ready);
endinterface

interface htq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] height_out;

	modport source (output valid, height_out, input ready);
	modport sink (input valid, height_out, output ready);
endinterface

interface htq_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/htq_ram.sv
module htq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/htq_ctrl.sv
module htq_ctrl import htq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_func,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WRITE = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_POST  = 4'd3;
	localparam logic [3:0] S_RD0   = 4'd4;
	localparam logic [3:0] S_RD1   = 4'd5;
	localparam logic [3:0] S_RD2   = 4'd6;
	localparam logic [3:0] S_RD3   = 4'd7;
	localparam logic [3:0] S_RD4   = 4'd8;
	localparam logic [3:0] S_SEL   = 4'd9;
	localparam logic [3:0] S_MUL1  = 4'd10;
	localparam logic [3:0] S_MUL2  = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_func == FUNC_QUERY) begin
						cmd.div_load = 1'b1;
						state_d      = S_DIV;
					end else begin
						cmd.wr_load = 1'b1;
						state_d     = S_WRITE;
					end
				end
			end
			S_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = S_IDLE;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_POST;
				end
			end
			S_POST: begin
				cmd.post = 1'b1;
				state_d  = S_RD0;
			end
			S_RD0: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_corner = CORNER_TL;
				state_d       = S_RD1;
			end
			S_RD1: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_corner  = CORNER_TR;
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = CORNER_TL;
				state_d        = S_RD2;
			end
			S_RD2: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_corner  = CORNER_BL;
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = CORNER_TR;
				state_d        = S_RD3;
			end
			S_RD3: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_corner  = CORNER_BR;
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = CORNER_BL;
				state_d        = S_RD4;
			end
			S_RD4: begin
				cmd.cap_en     = 1'b1;
				cmd.cap_corner = CORNER_BR;
				state_d        = S_SEL;
			end
			S_SEL: begin
				cmd.sel = 1'b1;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: rtl/htq_dp.sv
module htq_dp import htq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [5:0]         grid_row,
	input  logic [5:0]         grid_col,
	input  logic [7:0]         raw_height,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_z,
	output logic signed [31:0] height_out
);
	logic [7:0]  cs_q;
	logic [15:0] hs_q;
	logic [7:0]  cs_eff;

	// write path
	logic [5:0]  wr_row_q, wr_col_q;
	logic [7:0]  raw_q;
	logic        wr_ok;
	logic [23:0] wr_prod;

	// divider lanes
	logic [33:0] xa, za;
	logic [DIV_BITS-1:0] dvd_x_q, dvd_z_q;
	logic [7:0]  rem_x_q, rem_z_q;
	logic [CNT_W-1:0] cnt_q;
	logic [8:0]  tx, tz;
	logic        gex, gez;

	// cell selection
	logic signed [Q_W-1:0] xq, zq;
	logic signed [17:0]    col_raw, row_raw;
	logic [COL_W-1:0]      col_c, col_q;
	logic [ROW_W-1:0]      row_c, row_q;
	logic signed [Q_W-1:0] dx_q, dz_q;

	// memory
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
	logic [SAMPLE_W-1:0]   ram_rdata;
	logic [7:0]            rd_row, rd_col;
	logic [SAMPLE_W-1:0]   tl_q, tr_q, bl_q, br_q;

	// interpolation
	logic signed [Q_W:0]   dsum;
	logic                  lower;
	logic [SAMPLE_W-1:0]   base_c, n1_c, n2_c, base_q;
	logic signed [16:0]    c1_q, c2_q;
	logic signed [Q_W:0]   f1_q, f2_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [31:0]    sat;

	assign cs_eff = (cs_q == 8'd0) ? 8'd1 : cs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_RESET;
			hs_q <= HS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELL_SPACING: cs_q <= cfg_data[7:0];
				REG_HEIGHT_SCALE: hs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_load) begin
			wr_row_q <= grid_row;
			wr_col_q <= grid_col;
			raw_q    <= raw_height;
		end
	end

	assign wr_ok   = (int'(wr_row_q) < VERTS_PER_COL) && (int'(wr_col_q) < VERTS_PER_ROW);
	assign wr_prod = raw_q * hs_q;
	assign ram_we  = cmd.wr_en && wr_ok;
	assign ram_waddr = grid_addr({2'b00, wr_row_q}, {2'b00, wr_col_q});

	// biased dividends: floor(a / cs) = (a + cs * 2^23) / cs - 2^23
	assign xa = 34'(pos_x) + 34'(XS_OFF * cs_eff) + (34'(cs_eff) << BIAS_SH);
	assign za = 34'(ZS_OFF * cs_eff) + (34'(cs_eff) << BIAS_SH) - 34'(pos_z);

	assign tx  = {rem_x_q, dvd_x_q[DIV_BITS-1]};
	assign tz  = {rem_z_q, dvd_z_q[DIV_BITS-1]};
	assign gex = (tx >= {1'b0, cs_eff});
	assign gez = (tz >= {1'b0, cs_eff});
	assign sts.div_last = (cnt_q == CNT_W'(DIV_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_x_q <= xa[DIV_BITS-1:0];
			dvd_z_q <= za[DIV_BITS-1:0];
			rem_x_q <= '0;
			rem_z_q <= '0;
		end else if (cmd.div_step) begin
			dvd_x_q <= {dvd_x_q[DIV_BITS-2:0], gex};
			dvd_z_q <= {dvd_z_q[DIV_BITS-2:0], gez};
			rem_x_q <= gex ? 8'(tx - {1'b0, cs_eff}) : tx[7:0];
			rem_z_q <= gez ? 8'(tz - {1'b0, cs_eff}) : tz[7:0];
		end
	end

	assign xq = signed'(dvd_x_q[Q_W-1:0] - Q_W'(1 << BIAS_SH));
	assign zq = signed'(dvd_z_q[Q_W-1:0] - Q_W'(1 << BIAS_SH));
	assign col_raw = xq[Q_W-1:8];
	assign row_raw = zq[Q_W-1:8];

	always_comb begin
		priority if (col_raw >= 18'(VERTS_PER_ROW - 1)) begin
			col_c = COL_W'(VERTS_PER_ROW - 2);
		end else if (col_raw <= 18'sd0) begin
			col_c = '0;
		end else begin
			col_c = col_raw[COL_W-1:0];
		end
		priority if (row_raw >= 18'(VERTS_PER_COL - 1)) begin
			row_c = ROW_W'(VERTS_PER_COL - 2);
		end else if (row_raw <= 18'sd0) begin
			row_c = '0;
		end else begin
			row_c = row_raw[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			col_q <= col_c;
			row_q <= row_c;
			dx_q  <= xq - signed'(Q_W'(col_c) << 8);
			dz_q  <= zq - signed'(Q_W'(row_c) << 8);
		end
	end

	assign rd_row    = 8'(row_q) + 8'(cmd.rd_corner[1]);
	assign rd_col    = 8'(col_q) + 8'(cmd.rd_corner[0]);
	assign ram_raddr = grid_addr(rd_row, rd_col);

	htq_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_prod[23:8]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			unique case (cmd.cap_corner)
				CORNER_TL: tl_q <= ram_rdata;
				CORNER_TR: tr_q <= ram_rdata;
				CORNER_BL: bl_q <= ram_rdata;
				CORNER_BR: br_q <= ram_rdata;
				default: ;
			endcase
		end
	end

	assign dsum   = (Q_W+1)'(dx_q) + (Q_W+1)'(dz_q);
	assign lower  = (dsum < (Q_W+1)'(256));
	assign base_c = lower ? tl_q : br_q;
	assign n1_c   = lower ? tr_q : bl_q;
	assign n2_c   = lower ? bl_q : tr_q;

	always_ff @(posedge clk) begin
		if (cmd.sel) begin
			base_q <= base_c;
			c1_q   <= signed'({1'b0, n1_c}) - signed'({1'b0, base_c});
			c2_q   <= signed'({1'b0, n2_c}) - signed'({1'b0, base_c});
			f1_q   <= lower ? (Q_W+1)'(dx_q) : (Q_W+1)'(256) - (Q_W+1)'(dx_q);
			f2_q   <= lower ? (Q_W+1)'(dz_q) : (Q_W+1)'(256) - (Q_W+1)'(dz_q);
		end
		if (cmd.mul1) begin
			acc_q <= signed'(ACC_W'({base_q, 8'b0})) + ACC_W'(c1_q * f1_q);
		end else if (cmd.mul2) begin
			acc_q <= acc_q + ACC_W'(c2_q * f2_q);
		end
	end

	always_comb begin
		priority if (acc_q > ACC_W'(64'sd2147483647)) begin
			sat = 32'sh7fffffff;
		end else if (acc_q < -ACC_W'(64'sd2147483648)) begin
			sat = 32'sh80000000;
		end else begin
			sat = acc_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			height_out <= sat;
		end
	end
endmodule

// File: rtl/heightmap_triangle_height_query.sv
// Terrain heightmap with triangle-interpolated height lookup.
// req channel: func selects a sample write (grid_row, grid_col, raw_height)
//   or a height query at world (pos_x, pos_z), signed Q16.8.
// rsp channel: one height_out (signed Q24.8, saturated) per query; writes
//   return nothing.
// cfg channel: index 0 is cell_spacing, index 1 is height_scale (Q8.8);
//   always ready, write only while no transaction is in flight.
// Sequence: a write loads its operands, then writes the grid RAM. A query
//   runs a radix-2 divider (x and z lanes in parallel, one quotient bit per
//   cycle), a cell clamp, corner reads from the single-read-port grid RAM,
//   select and two multiplies, and a load of the output register; the next
//   request is taken once the block is back in idle.
// req.ready is high only while idle. A finished result waits in the output
//   register; if rsp stalls, the next query holds at its last step until the
//   register frees, while a write still goes through.
// Reset clears the control state and restores cell_spacing to 10 and
//   height_scale to 128; grid samples are undefined until written.
`include "heightmap_triangle_height_query_defines.svh"

module heightmap_triangle_height_query import htq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	htq_req_if.sink  req,
	htq_rsp_if.source rsp,
	htq_cfg_if.sink  cfg
);
	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	htq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_func  (req.func),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	htq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.grid_row  (req.grid_row),
		.grid_col  (req.grid_col),
		.raw_height(req.raw_height),
		.pos_x     (req.pos_x),
		.pos_z     (req.pos_z),
		.height_out(rsp.height_out)
	);

	`HTQ_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	`HTQ_ASSERT_NOW(a_one_datapath_op, 1'b1, $onehot0({cmd.wr_en, cmd.div_step, cmd.rd_en, cmd.mul1, cmd.mul2, cmd.emit}))
	`HTQ_ASSERT_NEXT(a_emit_shows_result, cmd.emit, rsp.valid)
endmodule
